// ===== src/afs_pkg.sv =====
`default_nettype none

package afs_pkg;

    // item actions
    typedef enum logic [2:0] {
        ACT_WRITE_MODE   = 3'd0,
        ACT_WRITE_ENABLE = 3'd1,
        ACT_READ_STATUS  = 3'd2,
        ACT_READ_MODE    = 3'd3,
        ACT_TICK         = 3'd4
    } action_t;

    // register indexes on the APB port (byte address = 4 * index)
    typedef enum logic [0:0] {
        REG_FRAME_PERIOD = 1'b0
    } reg_index_t;

    localparam int          PADDR_W             = 3;
    localparam int          PDATA_W             = 32;
    localparam logic [11:0] INIT_CYCLES         = 12'd2048;
    localparam logic [15:0] FRAME_PERIOD_RESET  = 16'd14915;
    localparam logic [2:0]  STEP_RESET          = 3'd4;
    localparam logic [2:0]  STEPS_FOUR          = 3'd4;
    localparam logic [2:0]  STEPS_FIVE          = 3'd5;
    localparam logic [7:0]  STATUS_FRAME_IRQ    = 8'h40;
    localparam logic [7:0]  STATUS_DMC_IRQ      = 8'h80;
    localparam logic [7:0]  MODE_READ_IDLE      = 8'h40;

    typedef struct packed {
        logic [16:0] master_count;
        logic [2:0]  step_index;
        logic        five_step_mode;
        logic        irq_enable;
        logic        frame_irq_flag;
        logic [11:0] init_countdown;
        logic        init_active;
        logic        irq_level;
    } seq_state_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       quarter_frame;
        logic       half_frame;
        logic       irq_line;
        logic       clear_dmc_irq;
    } result_t;

endpackage

`default_nettype wire

// ===== src/afs_if.sv =====
`default_nettype none

// command beat: one action per beat
interface afs_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] data;
    logic [7:0] cycles;
    logic [4:0] length_active;
    logic       dmc_irq;

    modport source (output valid, action, data, cycles, length_active, dmc_irq,
                    input ready);
    modport sink   (input valid, action, data, cycles, length_active, dmc_irq,
                    output ready);
endinterface

// response beat: one per command
interface afs_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       quarter_frame;
    logic       half_frame;
    logic       irq_line;
    logic       clear_dmc_irq;

    modport source (output valid, read_data, quarter_frame, half_frame, irq_line,
                    clear_dmc_irq, input ready);
    modport sink   (input valid, read_data, quarter_frame, half_frame, irq_line,
                    clear_dmc_irq, output ready);
endinterface

`default_nettype wire

// ===== src/afs_update.sv =====
`default_nettype none

// Next-state and response for one command beat.
module afs_update (
    input  afs_pkg::seq_state_t cur,
    input  logic [15:0]         frame_period,
    input  logic [2:0]          action,
    input  logic [7:0]          data,
    input  logic [7:0]          cycles,
    input  logic [4:0]          length_active,
    input  logic                dmc_irq,
    output afs_pkg::seq_state_t nxt,
    output afs_pkg::result_t    res
);

    logic [17:0] sum;
    logic [17:0] reduced;
    logic [2:0]  step_inc;
    logic [2:0]  step_new;
    logic [2:0]  limit;

    // master counter in 18 bits so the compare sees the carry
    assign sum      = {1'b0, cur.master_count} + {9'd0, cycles, 1'b0};
    assign reduced  = sum - {2'b00, frame_period};
    assign limit    = cur.five_step_mode ? afs_pkg::STEPS_FIVE : afs_pkg::STEPS_FOUR;
    assign step_inc = cur.step_index + 3'd1;
    assign step_new = (step_inc >= limit) ? 3'd0 : step_inc;

    always_comb
    begin
        nxt = cur;
        res = '0;
        unique case (afs_pkg::action_t'(action))
            afs_pkg::ACT_WRITE_MODE:
            begin
                nxt.five_step_mode = data[7];
                nxt.irq_enable     = ~data[6];
                nxt.master_count   = '0;
                nxt.frame_irq_flag = 1'b0;
                if (data[7])
                begin
                    // five-step mode clocks step 1 at once
                    nxt.step_index    = 3'd1;
                    res.quarter_frame = 1'b1;
                    res.half_frame    = 1'b1;
                end
                else
                begin
                    nxt.step_index = afs_pkg::STEP_RESET;
                end
            end
            afs_pkg::ACT_WRITE_ENABLE:
            begin
                if (data != 8'd0 && cur.init_countdown != 12'd0)
                    nxt.init_active = 1'b1;
            end
            afs_pkg::ACT_READ_STATUS:
            begin
                res.read_data = {3'd0, length_active}
                    | ((cur.frame_irq_flag && cur.irq_enable) ? afs_pkg::STATUS_FRAME_IRQ : 8'd0)
                    | (dmc_irq ? afs_pkg::STATUS_DMC_IRQ : 8'd0);
                nxt.frame_irq_flag = 1'b0;
                nxt.irq_level      = 1'b0;
                res.clear_dmc_irq  = 1'b1;
            end
            afs_pkg::ACT_READ_MODE:
            begin
                res.read_data = cur.frame_irq_flag ? 8'd0 : afs_pkg::MODE_READ_IDLE;
            end
            afs_pkg::ACT_TICK:
            begin
                if (cur.init_countdown != 12'd0 && cur.init_active)
                begin
                    if ({4'd0, cycles} >= cur.init_countdown)
                    begin
                        nxt.init_countdown = '0;
                        nxt.init_active    = 1'b0;
                    end
                    else
                    begin
                        nxt.init_countdown = cur.init_countdown - {4'd0, cycles};
                    end
                end
                else if (cycles != 8'd0)
                begin
                    nxt.irq_level = (cur.irq_enable & cur.frame_irq_flag) | dmc_irq;
                    if (sum >= {2'b00, frame_period})
                    begin
                        nxt.master_count  = reduced[16:0];
                        nxt.step_index    = step_new;
                        res.half_frame    = (step_new == 3'd1) || (step_new == 3'd3);
                        res.quarter_frame = (step_new < 3'd4);
                        if (step_new == 3'd3 && !cur.five_step_mode)
                            nxt.frame_irq_flag = 1'b1;
                    end
                    else
                    begin
                        nxt.master_count = sum[16:0];
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        res.irq_line = nxt.irq_level;
    end

endmodule

`default_nettype wire

// ===== src/apu_frame_sequencer_core.sv =====
`default_nettype none

// Audio frame sequencer. Each command beat carries one action: mode write,
// enable write, status read, mode read or a tick (cycles field N). A tick adds
// 2N half-cycles to the master counter; when it reaches frame_period one step
// is taken, producing quarter/half-frame strobes and, on step 3 in four-step
// mode, the frame IRQ flag. Every command gives exactly one response beat,
// in order. Throughput is one command per clock: the whole update is a single
// add/compare between the sequencer state registers and the response
// register, and a new command is taken whenever the response register is
// empty or being drained in the same cycle. The response is valid in the
// cycle after the command is accepted. frame_period sits at APB address 0
// (reset 14915) and should only be written with no command in flight.
module apu_frame_sequencer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    afs_cmd_if.sink                       cmd,
    afs_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [afs_pkg::PADDR_W-1:0]   paddr,
    input  logic [afs_pkg::PDATA_W-1:0]   pwdata,
    output logic [afs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    afs_pkg::seq_state_t state_reg;
    afs_pkg::seq_state_t state_next;
    afs_pkg::result_t    result_reg;
    afs_pkg::result_t    result_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic [15:0]         frame_period_reg;
    logic                accept;
    logic                cfg_wr;
    logic                addr_hit;

    // ---------------- APB register port ----------------
    // word index = paddr >> 2; only index 0 exists
    assign pready   = 1'b1;
    assign addr_hit = (afs_pkg::reg_index_t'(paddr[2]) == afs_pkg::REG_FRAME_PERIOD);
    assign cfg_wr   = psel && penable && pwrite && addr_hit;
    assign prdata   = addr_hit ? {16'd0, frame_period_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_period_reg <= afs_pkg::FRAME_PERIOD_RESET;
        else if (cfg_wr)
            frame_period_reg <= pwdata[15:0];
    end

    // ---------------- beat handshake ----------------
    // Response register doubles as the skid: a new command is taken while the
    // previous response leaves in the same cycle.
    assign cmd.ready      = !rsp_valid_reg || rsp.ready;
    assign accept         = cmd.valid && cmd.ready;
    assign rsp_valid_next = accept || (rsp_valid_reg && !rsp.ready);

    // ---------------- sequencer update ----------------
    afs_update u_update (
        .cur           (state_reg),
        .frame_period  (frame_period_reg),
        .action        (cmd.action),
        .data          (cmd.data),
        .cycles        (cmd.cycles),
        .length_active (cmd.length_active),
        .dmc_irq       (cmd.dmc_irq),
        .nxt           (state_next),
        .res           (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.master_count   <= '0;
            state_reg.step_index     <= afs_pkg::STEP_RESET;
            state_reg.five_step_mode <= 1'b0;
            state_reg.irq_enable     <= 1'b0;
            state_reg.frame_irq_flag <= 1'b0;
            state_reg.init_countdown <= afs_pkg::INIT_CYCLES;
            state_reg.init_active    <= 1'b0;
            state_reg.irq_level      <= 1'b0;
            rsp_valid_reg            <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
                state_reg <= state_next;
        end
    end

    // response payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.read_data     = result_reg.read_data;
    assign rsp.quarter_frame = result_reg.quarter_frame;
    assign rsp.half_frame    = result_reg.half_frame;
    assign rsp.irq_line      = result_reg.irq_line;
    assign rsp.clear_dmc_irq = result_reg.clear_dmc_irq;

`ifndef SYNTHESIS
    // step index never runs past the idle value
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.step_index <= afs_pkg::STEP_RESET)
        else $error("step index out of range");

    // start-up countdown only armed while cycles remain
    a_init_armed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.init_active |-> (state_reg.init_countdown != 12'd0))
        else $error("init active with empty countdown");

    // a half-frame step is always a quarter-frame step too
    a_half_quarter: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && result_reg.half_frame) |-> result_reg.quarter_frame)
        else $error("half frame without quarter frame");

    // status read drops the IRQ line
    a_status_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && result_reg.clear_dmc_irq) |-> !result_reg.irq_line)
        else $error("irq line high after status read");
`endif

endmodule

`default_nettype wire
